// File: sv/sfa_pkg.sv
// Shared types, codes and helpers for the spring force accumulator.
// No dependencies; imported by sfa_alu and spring_force_accumulator_core.
package sfa_pkg;

    // width of the shared add / compare unit (largest product is below 2^100)
    localparam int ALU_W = 100;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_SPRING = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_NORMAL_K = 2'd0,
        CFG_LONG_K   = 2'd1,
        CFG_REST_TOL = 2'd2
    } t_cfg_index;

    localparam logic [31:0] NORMAL_K_RST = 32'd65536;
    localparam logic [31:0] LONG_K_RST   = 32'd65536;
    localparam logic [30:0] REST_TOL_RST = 31'd66;

    // force magnitude clamp, 2^33
    localparam logic [33:0] F_CLAMP = 34'h200000000;

    // saturating accumulate of one force component
    function automatic logic [31:0] sat_acc(input logic signed [31:0] acc,
                                            input logic signed [34:0] f,
                                            input logic               sub);
        logic signed [35:0] s;
        begin
            s = sub ? (36'(acc) - 36'(f)) : (36'(acc) + 36'(f));
            if (s > 36'sd2147483647) begin
                sat_acc = 32'h7fffffff;
            end else if (s < -36'sd2147483648) begin
                sat_acc = 32'h80000000;
            end else begin
                sat_acc = s[31:0];
            end
        end
    endfunction

endpackage

// File: sv/sfa_alu.sv
// Shared wide add and compare-subtract unit.
// Depends on sfa_pkg for the operand width.
module sfa_alu (
    input  logic [sfa_pkg::ALU_W-1:0] i_a,
    input  logic [sfa_pkg::ALU_W-1:0] i_b,
    output logic [sfa_pkg::ALU_W-1:0] o_sum,
    output logic [sfa_pkg::ALU_W-1:0] o_diff,
    output logic                      o_ge
);
    import sfa_pkg::*;

    logic [ALU_W:0] w_sub;

    assign o_sum  = i_a + i_b;
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_sub[ALU_W-1:0];
    assign o_ge   = ~w_sub[ALU_W];

endmodule

// File: sv/sfa_ram.sv
// Simple one-write one-read memory with registered read data.
// No dependencies.
module sfa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 96,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/spring_force_accumulator_core.sv
// Spring force accumulator: position and force stores, one shared wide
// add/compare unit stepped by a sequencer. Depends on sfa_pkg, sfa_alu, sfa_ram.
// Write position and clear force finish with the beat. Read force: the store read is registered,
// then ST_RD_OUT loads the output register when it is free. Apply spring on the shared unit: 99 steps of squaring,
// 35 of root, 32 for e*k, then 33 multiply + 36 divide steps per axis.
// After reset the force store is swept to zero over all NUM_POINTS addresses, input not ready.
module spring_force_accumulator_core #(
    parameter int NUM_POINTS = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [9:0] first_point, [19:10] second_point, [50:20] rest_length,
    // [82:51] pos_x, [114:83] pos_y, [146:115] pos_z, [151:147] zero
    input  logic [151:0] i_s_axis_tdata,
    // [1:0] action, [2] stiff_kind
    input  logic [2:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] force_x, [63:32] force_y, [95:64] force_z
    output logic [95:0]  o_m_axis_tdata,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_wr_data
);
    import sfa_pkg::*;

    localparam int AW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_CLR    = 14'b00000000000010,
        ST_RD_OUT = 14'b00000000000100,
        ST_P_A    = 14'b00000000001000,
        ST_P_B    = 14'b00000000010000,
        ST_SQ     = 14'b00000000100000,
        ST_SQRT   = 14'b00000001000000,
        ST_CHK    = 14'b00000010000000,
        ST_EK     = 14'b00000100000000,
        ST_MUL    = 14'b00001000000000,
        ST_DIV    = 14'b00010000000000,
        ST_F_RDA  = 14'b00100000000000,
        ST_F_WRA  = 14'b01000000000000,
        ST_F_WRB  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    // config
    logic [31:0] r_k_norm, r_k_long;
    logic [30:0] r_tol;

    // latched item
    logic [AW-1:0] r_ia, n_ia, r_ib, n_ib;
    logic [30:0]   r_rest, n_rest;
    logic          r_kind, n_kind;
    logic          r_rd_zero, n_rd_zero;
    logic [AW-1:0] r_clr, n_clr;

    // datapath
    logic [95:0]        r_pa, n_pa;
    logic [32:0]        r_dmag [3];
    logic [32:0]        n_dmag [3];
    logic [2:0]         r_dneg, n_dneg;
    logic [ALU_W-1:0]   r_acc, n_acc, r_mc, n_mc;
    logic [32:0]        r_mp, n_mp;
    logic [5:0]         r_cnt, n_cnt;
    logic [1:0]         r_ax, n_ax;
    logic [37:0]        r_rem, n_rem;
    logic [34:0]        r_root, n_root;
    logic               r_str, n_str;
    logic [66:0]        r_ek, n_ek;
    logic [35:0]        r_q, n_q;
    logic signed [34:0] r_f [3];
    logic signed [34:0] n_f [3];

    // output register
    logic        r_out_valid, n_out_valid;
    logic [95:0] r_out_data, n_out_data;

    // input decode
    t_action     w_act;
    logic        w_kind;
    logic [9:0]  w_fp, w_sp;
    logic [30:0] w_rest;
    logic        w_a_ok, w_b_ok, w_acc_in;

    // memories
    logic          w_pos_we, w_pos_re, w_frc_we, w_frc_re;
    logic [AW-1:0] w_pos_raddr, w_frc_waddr, w_frc_raddr;
    logic [95:0]   w_pos_rdata, w_frc_wdata, w_frc_rdata;

    // shared unit
    logic [ALU_W-1:0] w_alu_a, w_alu_b, w_alu_sum, w_alu_diff;
    logic             w_alu_ge;

    logic signed [32:0] w_d [3];
    logic [ALU_W-1:0]   w_mul_acc;
    logic [35:0]        w_q_full;
    logic [33:0]        w_f_mag;
    logic               w_short, w_ge_rest;
    logic [34:0]        w_e;
    logic [31:0]        w_k;

    assign w_act    = t_action'(i_s_axis_tuser[1:0]);
    assign w_kind   = i_s_axis_tuser[2];
    assign w_fp     = i_s_axis_tdata[9:0];
    assign w_sp     = i_s_axis_tdata[19:10];
    assign w_rest   = i_s_axis_tdata[50:20];
    assign w_a_ok   = 32'(w_fp) < NUM_POINTS;
    assign w_b_ok   = 32'(w_sp) < NUM_POINTS;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_acc_in = i_s_axis_tvalid && o_s_axis_tready;

    assign w_pos_we    = w_acc_in && (w_act == ACT_WRITE) && w_a_ok;
    assign w_pos_re    = (w_acc_in && (w_act == ACT_SPRING)) || (r_state == ST_P_A);
    assign w_pos_raddr = (r_state == ST_P_A) ? r_ib : AW'(w_fp);

    sfa_ram #(.DEPTH(NUM_POINTS), .WIDTH(96), .AW(AW)) u_pos (
        .i_clk   (i_clk),
        .i_we    (w_pos_we),
        .i_waddr (AW'(w_fp)),
        .i_wdata (i_s_axis_tdata[146:51]),
        .i_re    (w_pos_re),
        .i_raddr (w_pos_raddr),
        .o_rdata (w_pos_rdata)
    );

    sfa_ram #(.DEPTH(NUM_POINTS), .WIDTH(96), .AW(AW)) u_frc (
        .i_clk   (i_clk),
        .i_we    (w_frc_we),
        .i_waddr (w_frc_waddr),
        .i_wdata (w_frc_wdata),
        .i_re    (w_frc_re),
        .i_raddr (w_frc_raddr),
        .o_rdata (w_frc_rdata)
    );

    sfa_alu u_alu (
        .i_a    (w_alu_a),
        .i_b    (w_alu_b),
        .o_sum  (w_alu_sum),
        .o_diff (w_alu_diff),
        .o_ge   (w_alu_ge)
    );

    // force store port control
    always_comb begin
        w_frc_we    = 1'b0;
        w_frc_waddr = r_ia;
        w_frc_wdata = '0;
        w_frc_re    = 1'b0;
        w_frc_raddr = r_ia;
        unique case (r_state)
            ST_CLR: begin
                w_frc_we    = 1'b1;
                w_frc_waddr = r_clr;
            end
            ST_IDLE: begin
                w_frc_we    = w_acc_in && (w_act == ACT_CLEAR) && w_a_ok;
                w_frc_waddr = AW'(w_fp);
                w_frc_re    = w_acc_in && (w_act == ACT_READ) && w_a_ok;
                w_frc_raddr = AW'(w_fp);
            end
            ST_F_RDA: begin
                w_frc_re = 1'b1;
            end
            ST_F_WRA: begin
                w_frc_we    = 1'b1;
                w_frc_re    = 1'b1;
                w_frc_raddr = r_ib;
                for (int i = 0; i < 3; i++) begin
                    w_frc_wdata[32*i +: 32] = sat_acc(w_frc_rdata[32*i +: 32], r_f[i], 1'b1);
                end
            end
            ST_F_WRB: begin
                w_frc_we    = 1'b1;
                w_frc_waddr = r_ib;
                for (int i = 0; i < 3; i++) begin
                    w_frc_wdata[32*i +: 32] = sat_acc(w_frc_rdata[32*i +: 32], r_f[i], 1'b0);
                end
            end
            default: begin
            end
        endcase
    end

    // shared unit operands
    always_comb begin
        w_alu_a = r_acc;
        w_alu_b = r_mc;
        if (r_state == ST_SQRT) begin
            w_alu_a = ALU_W'({r_rem, r_acc[69:68]});
            w_alu_b = ALU_W'({r_root, 2'b01});
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = 33'($signed(r_pa[32*i +: 32])) - 33'($signed(w_pos_rdata[32*i +: 32]));
        end
    end

    assign w_mul_acc = r_mp[0] ? w_alu_sum : r_acc;
    assign w_q_full  = {r_q[34:0], w_alu_ge};
    assign w_f_mag   = (w_q_full[35] || (w_q_full[34:0] > 35'(F_CLAMP))) ? F_CLAMP
                                                                         : w_q_full[33:0];
    assign w_short   = (r_root == '0) || (r_root < 35'(r_tol));
    assign w_ge_rest = r_root >= 35'(r_rest);
    assign w_e       = w_ge_rest ? (r_root - 35'(r_rest)) : (35'(r_rest) - r_root);
    assign w_k       = r_kind ? r_k_long : r_k_norm;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_ia        = r_ia;
        n_ib        = r_ib;
        n_rest      = r_rest;
        n_kind      = r_kind;
        n_rd_zero   = r_rd_zero;
        n_clr       = r_clr;
        n_pa        = r_pa;
        n_dmag      = r_dmag;
        n_dneg      = r_dneg;
        n_acc       = r_acc;
        n_mc        = r_mc;
        n_mp        = r_mp;
        n_cnt       = r_cnt;
        n_ax        = r_ax;
        n_rem       = r_rem;
        n_root      = r_root;
        n_str       = r_str;
        n_ek        = r_ek;
        n_q         = r_q;
        n_f         = r_f;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;

        unique case (r_state)
            ST_CLR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(NUM_POINTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_acc_in) begin
                    n_ia      = AW'(w_fp);
                    n_ib      = AW'(w_sp);
                    n_rest    = w_rest;
                    n_kind    = w_kind;
                    n_rd_zero = !w_a_ok;
                    if (w_act == ACT_READ) begin
                        n_state = ST_RD_OUT;
                    end else if ((w_act == ACT_SPRING) && w_a_ok && w_b_ok) begin
                        n_state = ST_P_A;
                    end
                end
            end
            ST_RD_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rd_zero ? '0 : w_frc_rdata;
                    n_state     = ST_IDLE;
                end
            end
            ST_P_A: begin
                n_pa    = w_pos_rdata;
                n_state = ST_P_B;
            end
            ST_P_B: begin
                for (int i = 0; i < 3; i++) begin
                    n_dneg[i] = w_d[i][32];
                    n_dmag[i] = w_d[i][32] ? 33'(-w_d[i]) : 33'(w_d[i]);
                end
                n_mc    = ALU_W'(n_dmag[0]);
                n_mp    = n_dmag[0];
                n_acc   = '0;
                n_ax    = 2'd0;
                n_cnt   = 6'd32;
                n_state = ST_SQ;
            end
            ST_SQ: begin
                // sum of squares, shift-add, one multiplier bit a cycle
                n_acc = w_mul_acc;
                n_mc  = r_mc << 1;
                n_mp  = r_mp >> 1;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    if (r_ax == 2'd2) begin
                        n_rem   = '0;
                        n_root  = '0;
                        n_cnt   = 6'd34;
                        n_state = ST_SQRT;
                    end else begin
                        n_ax  = r_ax + 2'd1;
                        n_mc  = ALU_W'(r_dmag[r_ax + 2'd1]);
                        n_mp  = r_dmag[r_ax + 2'd1];
                        n_cnt = 6'd32;
                    end
                end
            end
            ST_SQRT: begin
                // two radicand bits a step, root bit from compare-subtract
                n_acc = r_acc << 2;
                n_cnt = r_cnt - 6'd1;
                if (w_alu_ge) begin
                    n_rem  = w_alu_diff[37:0];
                    n_root = {r_root[33:0], 1'b1};
                end else begin
                    n_rem  = w_alu_a[37:0];
                    n_root = {r_root[33:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (w_short) begin
                    n_state = ST_IDLE;
                end else begin
                    n_str   = w_ge_rest;
                    n_mc    = ALU_W'(w_e);
                    n_mp    = 33'(w_k);
                    n_acc   = '0;
                    n_cnt   = 6'd31;
                    n_state = ST_EK;
                end
            end
            ST_EK: begin
                n_acc = w_mul_acc;
                n_mc  = r_mc << 1;
                n_mp  = r_mp >> 1;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    n_ek    = w_mul_acc[66:0];
                    n_mc    = ALU_W'(w_mul_acc[66:0]);
                    n_mp    = r_dmag[0];
                    n_acc   = '0;
                    n_ax    = 2'd0;
                    n_cnt   = 6'd32;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_acc = w_mul_acc;
                n_mc  = r_mc << 1;
                n_mp  = r_mp >> 1;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    // divisor len<<16, aligned for quotient bit 35
                    n_mc    = ALU_W'(r_root) << 51;
                    n_q     = '0;
                    n_cnt   = 6'd35;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_alu_ge) begin
                    n_acc = w_alu_diff;
                end
                n_mc  = r_mc >> 1;
                n_q   = w_q_full;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    n_f[r_ax] = (r_dneg[r_ax] == r_str) ? -$signed({1'b0, w_f_mag})
                                                        : $signed({1'b0, w_f_mag});
                    if (r_ax == 2'd2) begin
                        n_state = ST_F_RDA;
                    end else begin
                        n_ax    = r_ax + 2'd1;
                        n_mc    = ALU_W'(r_ek);
                        n_mp    = r_dmag[r_ax + 2'd1];
                        n_acc   = '0;
                        n_cnt   = 6'd32;
                        n_state = ST_MUL;
                    end
                end
            end
            ST_F_RDA: begin
                n_state = ST_F_WRA;
            end
            ST_F_WRA: begin
                n_state = ST_F_WRB;
            end
            ST_F_WRB: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_k_norm    <= NORMAL_K_RST;
            r_k_long    <= LONG_K_RST;
            r_tol       <= REST_TOL_RST;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_NORMAL_K: r_k_norm <= i_cfg_wr_data;
                    CFG_LONG_K:   r_k_long <= i_cfg_wr_data;
                    CFG_REST_TOL: r_tol    <= i_cfg_wr_data[30:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ia       <= n_ia;
        r_ib       <= n_ib;
        r_rest     <= n_rest;
        r_kind     <= n_kind;
        r_rd_zero  <= n_rd_zero;
        r_pa       <= n_pa;
        r_dmag     <= n_dmag;
        r_dneg     <= n_dneg;
        r_acc      <= n_acc;
        r_mc       <= n_mc;
        r_mp       <= n_mp;
        r_cnt      <= n_cnt;
        r_ax       <= n_ax;
        r_rem      <= n_rem;
        r_root     <= n_root;
        r_str      <= n_str;
        r_ek       <= n_ek;
        r_q        <= n_q;
        r_f        <= n_f;
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_single_beat_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_in && ((w_act == ACT_WRITE) || (w_act == ACT_CLEAR))) |=> (r_state == ST_IDLE))
        else $error("write/clear beat did not complete in one cycle");

    a_read_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_in && (w_act == ACT_READ)) |=> (r_state == ST_RD_OUT))
        else $error("read beat did not move to result stage");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == ST_RD_OUT))
        else $error("result raised outside of read");

    a_force_wr_spring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_F_WRA) |-> ($past(r_state) == ST_F_RDA) && (r_ax == 2'd2))
        else $error("force update out of sequence");

endmodule
